### src/vn_pkg.sv
// Shared type for the four-component normaliser.
package vn_pkg;

   typedef struct packed {
      logic neg;
      logic kill;
      logic near_zero;
   } vn_lane_ctl_type;

endpackage

### src/vector4_normalizer_top.sv
// Four-component Q16.16 normaliser: magnitude, unit tuple and near-zero flag.
//
// Input beats arrive on req_valid/req_ready carrying four signed components.
// Each beat gives one rsp beat with the four unit components, the magnitude
// (floor of the square root of the sum of squares) and the near-zero flag.
// When the magnitude is below the limit in csr_wr_data (written when
// csr_wr_en is high) the unit components are zero.
// Pipeline: abs, square, sum, one square-root stage per result bit
// (COMP_WIDTH+1), four parallel divider lanes of FRAC_BITS+2 stages, and
// the output register. One beat per cycle is taken while the output is not
// stalled. The whole pipeline advances together; when rsp_valid is held
// with rsp_ready low it freezes and req_ready drops, otherwise req_ready
// stays high even while a result waits in the output register.
// Reset empties the pipeline and sets the near-zero limit to 1.
module vector4_normalizer_top
   import vn_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int COMP_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COMP_WIDTH-1:0]  req_comp_x,
   input  logic signed [COMP_WIDTH-1:0]  req_comp_y,
   input  logic signed [COMP_WIDTH-1:0]  req_comp_z,
   input  logic signed [COMP_WIDTH-1:0]  req_comp_w,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [FRAC_BITS+1:0]   rsp_unit_x,
   output logic signed [FRAC_BITS+1:0]   rsp_unit_y,
   output logic signed [FRAC_BITS+1:0]   rsp_unit_z,
   output logic signed [FRAC_BITS+1:0]   rsp_unit_w,
   output logic [COMP_WIDTH:0]           rsp_length,
   output logic                          rsp_near_zero,
   input  logic                          csr_wr_en,
   input  logic [16:0]                   csr_wr_data
);

   localparam int CW   = COMP_WIDTH;
   localparam int LW   = COMP_WIDTH + 1;
   localparam int UW   = FRAC_BITS + 2;
   localparam int SUMW = 2 * COMP_WIDTH + 2;
   localparam int SW   = 4 * (COMP_WIDTH + 1);

   logic          advance;
   logic [16:0]   limit_ff;

   logic [CW-1:0]   comp [4];
   logic [CW-1:0]   abs_ff [4];
   logic            neg_a_ff [4];
   logic            va_ff;
   logic [2*CW-1:0] sq_ff [4];
   logic [CW-1:0]   abs_b_ff [4];
   logic            neg_b_ff [4];
   logic            vb_ff;
   logic [SUMW-1:0] sum_ff;
   logic [CW-1:0]   abs_c_ff [4];
   logic            neg_c_ff [4];
   logic            vc_ff;

   logic [SW-1:0]   side_c;
   logic [SW-1:0]   side_s;
   logic            vs;
   logic [LW-1:0]   root_s;
   logic            small_s;
   logic            kill_s;

   logic              lane_valid [4];
   logic [UW-1:0]     lane_unit  [4];
   logic [LW-1:0]     lane_len   [4];
   vn_lane_ctl_type   lane_ctl   [4];

   logic            rsp_valid_ff;
   logic [UW-1:0]   unit_ff [4];
   logic [LW-1:0]   len_ff;
   logic            nz_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign comp[0] = req_comp_x;
   assign comp[1] = req_comp_y;
   assign comp[2] = req_comp_z;
   assign comp[3] = req_comp_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 17'd1;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         va_ff        <= req_valid;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         rsp_valid_ff <= lane_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            neg_a_ff[i] <= comp[i][CW-1];
            abs_ff[i]   <= comp[i][CW-1] ? (~comp[i] + CW'(1)) : comp[i];
            sq_ff[i]    <= (2*CW)'(abs_ff[i]) * (2*CW)'(abs_ff[i]);
            abs_b_ff[i] <= abs_ff[i];
            neg_b_ff[i] <= neg_a_ff[i];
            abs_c_ff[i] <= abs_b_ff[i];
            neg_c_ff[i] <= neg_b_ff[i];
         end
         sum_ff <= SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]) + SUMW'(sq_ff[3]);
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         side_c[i*LW +: LW] = {neg_c_ff[i], abs_c_ff[i]};
      end
   end

   vn_sqrt #(
      .COMP_WIDTH (COMP_WIDTH),
      .SIDE_W     (SW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (vc_ff),
      .in_sum    (sum_ff),
      .in_side   (side_c),
      .out_valid (vs),
      .out_root  (root_s),
      .out_side  (side_s)
   );

   assign small_s = root_s < LW'(limit_ff);
   assign kill_s  = small_s || (root_s == '0);

   for (genvar i = 0; i < 4; i++) begin : g_lane
      vn_lane_ctl_type ctl;
      assign ctl.neg       = side_s[i*LW + CW];
      assign ctl.kill      = kill_s;
      assign ctl.near_zero = small_s;

      vn_div_lane #(
         .FRAC_BITS  (FRAC_BITS),
         .COMP_WIDTH (COMP_WIDTH)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (vs),
         .in_mag    (side_s[i*LW +: CW]),
         .in_len    (root_s),
         .in_ctl    (ctl),
         .out_valid (lane_valid[i]),
         .out_unit  (lane_unit[i]),
         .out_len   (lane_len[i]),
         .out_ctl   (lane_ctl[i])
      );
   end

   // merge lanes into the output beat
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            unit_ff[i] <= lane_unit[i];
         end
         len_ff <= lane_len[0];
         nz_ff  <= lane_ctl[0].near_zero;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_unit_x    = unit_ff[0];
   assign rsp_unit_y    = unit_ff[1];
   assign rsp_unit_z    = unit_ff[2];
   assign rsp_unit_w    = unit_ff[3];
   assign rsp_length    = len_ff;
   assign rsp_near_zero = nz_ff;

   a_nz_units_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_near_zero |->
         rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0 && rsp_unit_w == '0)
      else $error("near-zero beat with non-zero unit");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with output free");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      lane_valid[0] == lane_valid[1] && lane_valid[0] == lane_valid[2] &&
      lane_valid[0] == lane_valid[3])
      else $error("lanes out of step");

   a_limit_reset: assert property (@(posedge clock)
      $past(reset) && !$past(csr_wr_en) |-> limit_ff == 17'd1)
      else $error("limit not reset");

endmodule

### src/vn_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side-band carried alongside.
module vn_sqrt
   import vn_pkg::*;
#(
   parameter int COMP_WIDTH = 32,
   parameter int SIDE_W     = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [2*COMP_WIDTH+1:0] in_sum,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic [COMP_WIDTH:0]     out_root,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int N    = COMP_WIDTH + 1;
   localparam int SUMW = 2 * COMP_WIDTH + 2;
   localparam int RW   = COMP_WIDTH + 4;

   logic [RW-1:0]         rem_ff  [N];
   logic [COMP_WIDTH:0]   root_ff [N];
   logic [SUMW-1:0]       s_ff    [N];
   logic [SIDE_W-1:0]     side_ff [N];
   logic                  vld_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [RW-1:0]       rem_p;
      logic [RW-1:0]       rem_t;
      logic [RW-1:0]       trial;
      logic [COMP_WIDTH:0] root_p;
      logic [SUMW-1:0]     s_p;
      logic [SIDE_W-1:0]   side_p;
      logic                v_p;
      logic                ge;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign s_p    = in_sum;
         assign side_p = in_side;
         assign v_p    = in_valid;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign s_p    = s_ff[k-1];
         assign side_p = side_ff[k-1];
         assign v_p    = vld_ff[k-1];
      end

      assign rem_t = {rem_p[RW-3:0], s_p[SUMW-1 -: 2]};
      assign trial = RW'({root_p, 2'b01});
      assign ge    = rem_t >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= ge ? (rem_t - trial) : rem_t;
            root_ff[k] <= {root_p[COMP_WIDTH-1:0], ge};
            s_ff[k]    <= {s_p[SUMW-3:0], 2'b00};
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

### src/vn_div_lane.sv
// One divider lane: pipelined restoring division giving a rounded signed unit component.
module vn_div_lane
   import vn_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int COMP_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [COMP_WIDTH-1:0]   in_mag,
   input  logic [COMP_WIDTH:0]     in_len,
   input  vn_lane_ctl_type         in_ctl,
   output logic                    out_valid,
   output logic signed [FRAC_BITS+1:0] out_unit,
   output logic [COMP_WIDTH:0]     out_len,
   output vn_lane_ctl_type         out_ctl
);

   localparam int N  = FRAC_BITS + 2;
   localparam int UW = FRAC_BITS + 2;
   localparam int LW = COMP_WIDTH + 1;
   localparam logic [UW-1:0] ONE = UW'(1) << FRAC_BITS;

   logic [LW-1:0]   rem_ff [N];
   logic [UW-1:0]   q_ff   [N];
   logic [LW-1:0]   len_ff [N];
   vn_lane_ctl_type ctl_ff [N];
   logic            vld_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [LW-1:0]   rem_p;
      logic [UW-1:0]   q_p;
      logic [LW-1:0]   len_p;
      vn_lane_ctl_type ctl_p;
      logic            v_p;
      logic [LW-1:0]   rem_in;
      logic [UW-1:0]   q_in;

      if (k == 0) begin : g_first
         assign rem_p = LW'(in_mag);
         assign q_p   = '0;
         assign len_p = in_len;
         assign ctl_p = in_ctl;
         assign v_p   = in_valid;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign q_p   = q_ff[k-1];
         assign len_p = len_ff[k-1];
         assign ctl_p = ctl_ff[k-1];
         assign v_p   = vld_ff[k-1];
      end

      always_comb begin
         logic [LW:0]   rem2;
         logic [LW-1:0] diff;
         logic [UW-1:0] qr;
         logic          ge;
         rem2   = {rem_p, 1'b0};
         diff   = '0;
         qr     = '0;
         ge     = 1'b0;
         rem_in = rem_p;
         q_in   = q_p;
         if (k == 0) begin
            ge     = rem_p >= len_p;
            diff   = rem_p - len_p;
            rem_in = ge ? ((diff >= len_p) ? '0 : diff) : rem_p;
            q_in   = UW'(ge);
         end else if (k < N - 1) begin
            ge     = rem2 >= {1'b0, len_p};
            rem_in = ge ? LW'(rem2 - {1'b0, len_p}) : LW'(rem2);
            q_in   = {q_p[UW-2:0], ge};
         end else begin
            ge = rem2 >= {1'b0, len_p};
            qr = q_p + UW'(ge);
            if (qr > ONE) begin
               qr = ONE;
            end
            if (ctl_p.kill) begin
               q_in = '0;
            end else if (ctl_p.neg) begin
               q_in = ~qr + UW'(1);
            end else begin
               q_in = qr;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
            len_ff[k] <= len_p;
            ctl_ff[k] <= ctl_p;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_unit  = q_ff[N-1];
   assign out_len   = len_ff[N-1];
   assign out_ctl   = ctl_ff[N-1];

endmodule
